// File: hw/rtl/lda_gibbs_token_sampler_assert.svh
// Assertion macros for the LDA token sampler checker.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef LDA_GIBBS_TOKEN_SAMPLER_ASSERT_SVH
`define LDA_GIBBS_TOKEN_SAMPLER_ASSERT_SVH

// next-cycle implication, off during reset
`define LGTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lgts: check failed");

// next-cycle implication from reset itself
`define LGTS_ASSERT_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("lgts: reset check failed");

`endif

// File: hw/rtl/lgts_pkg.sv
// Shared constants and types of the LDA token sampler.
// No dependencies; used by the interfaces, the divider and the top level.
package lgts_pkg;

   localparam int MAX_TOPICS    = 64;
   localparam int TOPIC_BITS    = 6;
   localparam int KCNT_BITS     = TOPIC_BITS + 1;
   localparam int VOCAB_SIZE    = 4096;
   localparam int TERM_BITS     = 12;
   localparam int MAX_DOCS      = 1024;
   localparam int DOC_BITS      = 10;
   localparam int COUNT_BITS    = 20;
   localparam int TOTAL_BITS    = 24;
   localparam int FRAC_BITS     = 8;
   localparam int PRIOR_BITS    = 16;
   localparam int KREG_BITS     = 7;
   localparam int VOCAB_BITS    = 13;
   localparam int RAND_BITS     = 32;
   localparam int DT_ADDR_BITS  = DOC_BITS + TOPIC_BITS;
   localparam int TT_ADDR_BITS  = TOPIC_BITS + TERM_BITS;
   localparam int DT_DEPTH      = MAX_DOCS * MAX_TOPICS;
   localparam int OPER_BITS     = COUNT_BITS + FRAC_BITS + 1;
   localparam int NUM_BITS      = 2 * OPER_BITS;
   localparam int VB_BITS       = VOCAB_BITS + PRIOR_BITS;
   localparam int DEN_BITS      = TOTAL_BITS + FRAC_BITS + 1;
   localparam int WEIGHT_BITS   = 32;
   localparam int DIVD_BITS     = NUM_BITS + FRAC_BITS;
   localparam int SUM_BITS      = WEIGHT_BITS + TOPIC_BITS;
   localparam int PROD_BITS     = RAND_BITS + WEIGHT_BITS;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [PRIOR_BITS-1:0] ALPHA_RESET  = 16'd26;
   localparam logic [PRIOR_BITS-1:0] BETA_RESET   = 16'd3;
   localparam logic [KREG_BITS-1:0]  TOPICS_RESET = 7'd64;
   localparam logic [VOCAB_BITS-1:0] VOCAB_RESET  = 13'd4096;

   typedef enum logic [1:0] {
      CSR_ALPHA  = 2'd0,
      CSR_BETA   = 2'd1,
      CSR_TOPICS = 2'd2,
      CSR_VOCAB  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  valid;
      logic [TOPIC_BITS-1:0] tag;
      logic [NUM_BITS-1:0]   num;
      logic [DEN_BITS-1:0]   den;
   } div_in_type;

   typedef struct packed {
      logic                   valid;
      logic [TOPIC_BITS-1:0]  tag;
      logic [WEIGHT_BITS-1:0] weight;
   } div_out_type;

endpackage

// File: hw/rtl/lgts_if.sv
// Request and response channel interfaces of the LDA token sampler.
// Depends on lgts_pkg for field widths.
interface lgts_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic [lgts_pkg::DOC_BITS-1:0]   doc_index;
   logic [lgts_pkg::TERM_BITS-1:0]  term_index;
   logic [lgts_pkg::TOPIC_BITS-1:0] old_topic;
   logic [lgts_pkg::RAND_BITS-1:0]  random_draw;

   modport source (output valid, req_type, doc_index, term_index, old_topic, random_draw,
                   input ready);
   modport sink   (input valid, req_type, doc_index, term_index, old_topic, random_draw,
                   output ready);
endinterface

interface lgts_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lgts_pkg::TOPIC_BITS-1:0] new_topic;
   logic                            error;

   modport source (output valid, new_topic, error, input ready);
   modport sink   (input valid, new_topic, error, output ready);
endinterface

// File: hw/rtl/lda_gibbs_token_sampler.sv
// Collapsed Gibbs token sampler for LDA. Count tables live in on-chip memories and are zeroed by
// a clearing pass after reset, during which no request is taken. An assign request reads, checks
// and increments the counts of its topic. A resample makes one pass of K memory reads for the K
// topics in use feeding a pipelined divider, forms the threshold product in S_THR0 and S_THR1,
// and makes one pass over the weight memory for the selection.
// Depends on lgts_pkg, lgts_if and lgts_div.
module lda_gibbs_token_sampler (
   input  logic                               clock,
   input  logic                               reset,
   lgts_req_if.sink                           req_bus,
   lgts_rsp_if.source                         rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lgts_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [lgts_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [lgts_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   import lgts_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR   = 11'b00000000001,
      S_IDLE    = 11'b00000000010,
      S_RD_OLD  = 11'b00000000100,
      S_CHK     = 11'b00000001000,
      S_WEIGHT  = 11'b00000010000,
      S_THR0    = 11'b00000100000,
      S_THR1    = 11'b00001000000,
      S_SELECT  = 11'b00010000000,
      S_RD_PICK = 11'b00100000000,
      S_WR_PICK = 11'b01000000000,
      S_DONE    = 11'b10000000000
   } state_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   // memories
   logic [COUNT_BITS-1:0]  dt_mem  [0:DT_DEPTH-1];
   logic [COUNT_BITS-1:0]  tt_mem  [0:MAX_TOPICS*VOCAB_SIZE-1];
   logic [TOTAL_BITS-1:0]  tot_mem [0:MAX_TOPICS-1];
   logic [WEIGHT_BITS-1:0] ws_mem  [0:MAX_TOPICS-1];
   logic [COUNT_BITS-1:0]  dt_q_ff, tt_q_ff;
   logic [TOTAL_BITS-1:0]  tot_q_ff;
   logic [WEIGHT_BITS-1:0] ws_q_ff;

   logic                    cnt_we, dt_we, tot_we, ws_we;
   logic [DT_ADDR_BITS-1:0] dt_ra, dt_wa;
   logic [TT_ADDR_BITS-1:0] tt_ra, tt_wa;
   logic [TOPIC_BITS-1:0]   rd_topic, wr_topic, tot_wa;
   logic [COUNT_BITS-1:0]   dt_wd, tt_wd;
   logic [TOTAL_BITS-1:0]   tot_wd;

   // config
   logic [PRIOR_BITS-1:0] alpha_ff, alpha_in, beta_ff, beta_in;
   logic [KREG_BITS-1:0]  topics_ff, topics_in;
   logic [VOCAB_BITS-1:0] vocab_ff, vocab_in;
   logic [VB_BITS-1:0]    vb_ff;
   logic [KCNT_BITS-1:0]  k_eff;
   logic                  csr_we;
   csr_index_type         csr_idx;

   // control and datapath
   state_type               state_ff, state_in;
   logic [TT_ADDR_BITS-1:0] clr_ff, clr_in;
   logic                    type_ff, type_in;
   logic [DOC_BITS-1:0]     doc_ff, doc_in;
   logic [TERM_BITS-1:0]    term_ff, term_in;
   logic [TOPIC_BITS-1:0]   topic_ff, topic_in;
   logic [RAND_BITS-1:0]    rnd_ff, rnd_in;
   logic [KCNT_BITS-1:0]    wk_ff, wk_in, wd_ff, wd_in, sk_ff, sk_in;
   logic                    rv_ff, rv_in, sv_ff, sv_in;
   logic [TOPIC_BITS-1:0]   rtag_ff, rtag_in, stag_ff, stag_in, pick_ff, pick_in;
   logic                    sa_valid_ff;
   logic [TOPIC_BITS-1:0]   sa_tag_ff;
   logic [OPER_BITS-1:0]    sa_a_ff, sa_b_ff;
   logic [DEN_BITS-1:0]     sa_d_ff;
   div_in_type              div_in_ff;
   div_out_type             div_out;
   logic [SUM_BITS-1:0]     sum_ff, sum_in, thr_ff, thr_in, run_ff, run_in, run_next;
   logic [PROD_BITS-1:0]    plo_ff, plo_in;
   logic [TOPIC_BITS-1:0]   res_topic_ff, res_topic_in;
   logic                    res_err_ff, res_err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TOPIC_BITS-1:0]   rsp_topic_ff, rsp_topic_in;
   logic                    rsp_err_ff, rsp_err_in;
   logic                    range_err, chk_err, req_take, rsp_load;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_we  = psel & penable & pwrite;
   assign csr_idx = csr_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      alpha_in  = alpha_ff;
      beta_in   = beta_ff;
      topics_in = topics_ff;
      vocab_in  = vocab_ff;
      if (csr_we) begin
         unique case (csr_idx)
            CSR_ALPHA:  alpha_in  = pwdata[PRIOR_BITS-1:0];
            CSR_BETA:   beta_in   = pwdata[PRIOR_BITS-1:0];
            CSR_TOPICS: topics_in = pwdata[KREG_BITS-1:0];
            CSR_VOCAB:  vocab_in  = pwdata[VOCAB_BITS-1:0];
            default:    alpha_in  = alpha_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_ALPHA:  prdata = CSR_DATA_BITS'(alpha_ff);
         CSR_BETA:   prdata = CSR_DATA_BITS'(beta_ff);
         CSR_TOPICS: prdata = CSR_DATA_BITS'(topics_ff);
         CSR_VOCAB:  prdata = CSR_DATA_BITS'(vocab_ff);
         default:    prdata = '0;
      endcase
   end

   assign k_eff = (topics_ff < KREG_BITS'(MAX_TOPICS)) ? KCNT_BITS'(topics_ff)
                                                       : KCNT_BITS'(MAX_TOPICS);

   // ---------------- memory ports ----------------
   assign rd_topic = (state_ff == S_WEIGHT)  ? wk_ff[TOPIC_BITS-1:0] :
                     (state_ff == S_RD_PICK) ? pick_ff : topic_ff;
   assign wr_topic = (state_ff == S_WR_PICK) ? pick_ff : topic_ff;
   assign dt_ra    = {doc_ff, rd_topic};
   assign tt_ra    = {rd_topic, term_ff};

   always_comb begin
      cnt_we = 1'b0;
      dt_we  = 1'b0;
      tot_we = 1'b0;
      dt_wa  = {doc_ff, wr_topic};
      tt_wa  = {wr_topic, term_ff};
      tot_wa = wr_topic;
      dt_wd  = dt_q_ff + COUNT_BITS'(1);
      tt_wd  = tt_q_ff + COUNT_BITS'(1);
      tot_wd = tot_q_ff + TOTAL_BITS'(1);
      priority case (1'b1)
         (state_ff == S_CLEAR): begin
            cnt_we = 1'b1;
            dt_we  = (clr_ff < TT_ADDR_BITS'(DT_DEPTH));
            tot_we = (clr_ff < TT_ADDR_BITS'(MAX_TOPICS));
            dt_wa  = clr_ff[DT_ADDR_BITS-1:0];
            tt_wa  = clr_ff;
            tot_wa = clr_ff[TOPIC_BITS-1:0];
            dt_wd  = '0;
            tt_wd  = '0;
            tot_wd = '0;
         end
         (state_ff == S_CHK): begin
            cnt_we = !chk_err;
            dt_we  = !chk_err;
            tot_we = !chk_err;
            if (type_ff) begin
               dt_wd  = dt_q_ff - COUNT_BITS'(1);
               tt_wd  = tt_q_ff - COUNT_BITS'(1);
               tot_wd = tot_q_ff - TOTAL_BITS'(1);
            end
         end
         (state_ff == S_WR_PICK): begin
            cnt_we = 1'b1;
            dt_we  = 1'b1;
            tot_we = 1'b1;
         end
         default: cnt_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (dt_we) begin
         dt_mem[dt_wa] <= dt_wd;
      end
      dt_q_ff <= dt_mem[dt_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         tt_mem[tt_wa] <= tt_wd;
      end
      tt_q_ff <= tt_mem[tt_ra];
   end

   always_ff @(posedge clock) begin
      if (tot_we) begin
         tot_mem[tot_wa] <= tot_wd;
      end
      tot_q_ff <= tot_mem[rd_topic];
   end

   assign ws_we = (state_ff == S_WEIGHT) && div_out.valid;

   always_ff @(posedge clock) begin
      if (ws_we) begin
         ws_mem[div_out.tag] <= div_out.weight;
      end
      ws_q_ff <= ws_mem[sk_ff[TOPIC_BITS-1:0]];
   end

   // ---------------- weight datapath ----------------
   always_ff @(posedge clock) begin
      sa_tag_ff       <= rtag_ff;
      sa_a_ff         <= OPER_BITS'({dt_q_ff, {FRAC_BITS{1'b0}}}) + OPER_BITS'(alpha_ff);
      sa_b_ff         <= OPER_BITS'({tt_q_ff, {FRAC_BITS{1'b0}}}) + OPER_BITS'(beta_ff);
      sa_d_ff         <= DEN_BITS'({tot_q_ff, {FRAC_BITS{1'b0}}}) + DEN_BITS'(vb_ff);
      div_in_ff.tag   <= sa_tag_ff;
      div_in_ff.num   <= NUM_BITS'(sa_a_ff) * NUM_BITS'(sa_b_ff);
      div_in_ff.den   <= sa_d_ff;
      vb_ff           <= VB_BITS'(vocab_ff) * VB_BITS'(beta_ff);
      if (reset) begin
         sa_valid_ff     <= 1'b0;
         div_in_ff.valid <= 1'b0;
      end else begin
         sa_valid_ff     <= rv_ff;
         div_in_ff.valid <= sa_valid_ff;
      end
   end

   lgts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in_ff),
      .div_out (div_out)
   );

   // ---------------- sequencer ----------------
   assign range_err = ({1'b0, req_bus.doc_index} >= (DOC_BITS+1)'(MAX_DOCS)) ||
                      ({1'b0, req_bus.term_index} >= (TERM_BITS+1)'(VOCAB_SIZE)) ||
                      (VOCAB_BITS'(req_bus.term_index) >= vocab_ff) ||
                      (KCNT_BITS'(req_bus.old_topic) >= k_eff);
   assign chk_err   = type_ff ? (dt_q_ff == '0 || tt_q_ff == '0 || tot_q_ff == '0)
                              : (dt_q_ff == COUNT_MAX || tt_q_ff == COUNT_MAX ||
                                 tot_q_ff == TOTAL_MAX);
   assign req_take  = req_bus.valid && (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   assign run_next  = run_ff + SUM_BITS'(ws_q_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      type_in      = type_ff;
      doc_in       = doc_ff;
      term_in      = term_ff;
      topic_in     = topic_ff;
      rnd_in       = rnd_ff;
      wk_in        = wk_ff;
      wd_in        = wd_ff;
      sk_in        = sk_ff;
      rv_in        = 1'b0;
      rtag_in      = wk_ff[TOPIC_BITS-1:0];
      sv_in        = 1'b0;
      stag_in      = sk_ff[TOPIC_BITS-1:0];
      pick_in      = pick_ff;
      sum_in       = sum_ff;
      plo_in       = plo_ff;
      thr_in       = thr_ff;
      run_in       = run_ff;
      res_topic_in = res_topic_ff;
      res_err_in   = res_err_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + TT_ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               type_in      = req_bus.req_type;
               doc_in       = req_bus.doc_index;
               term_in      = req_bus.term_index;
               topic_in     = req_bus.old_topic;
               rnd_in       = req_bus.random_draw;
               res_topic_in = req_bus.old_topic;
               res_err_in   = 1'b1;
               state_in     = range_err ? S_DONE : S_RD_OLD;
            end
         end
         S_RD_OLD: state_in = S_CHK;
         S_CHK: begin
            if (chk_err || !type_ff) begin
               res_err_in = chk_err;
               state_in   = S_DONE;
            end else begin
               wk_in    = '0;
               wd_in    = '0;
               sum_in   = '0;
               state_in = S_WEIGHT;
            end
         end
         S_WEIGHT: begin
            if (wk_ff < k_eff) begin
               rv_in = 1'b1;
               wk_in = wk_ff + KCNT_BITS'(1);
            end
            if (div_out.valid) begin
               sum_in = sum_ff + SUM_BITS'(div_out.weight);
               wd_in  = wd_ff + KCNT_BITS'(1);
               if (wd_ff + KCNT_BITS'(1) == k_eff) begin
                  state_in = S_THR0;
               end
            end
         end
         S_THR0: begin
            plo_in   = PROD_BITS'(rnd_ff) * PROD_BITS'(sum_ff[WEIGHT_BITS-1:0]);
            state_in = S_THR1;
         end
         S_THR1: begin
            thr_in   = SUM_BITS'(rnd_ff) * SUM_BITS'(sum_ff[SUM_BITS-1:WEIGHT_BITS]) +
                       SUM_BITS'(plo_ff[PROD_BITS-1:WEIGHT_BITS]);
            sk_in    = '0;
            run_in   = '0;
            state_in = S_SELECT;
         end
         S_SELECT: begin
            if (sk_ff < k_eff) begin
               sv_in = 1'b1;
               sk_in = sk_ff + KCNT_BITS'(1);
            end
            if (sv_ff) begin
               run_in = run_next;
               // last topic is the fallback when nothing crosses the threshold
               if (run_next > thr_ff || KCNT_BITS'(stag_ff) == k_eff - KCNT_BITS'(1)) begin
                  pick_in  = stag_ff;
                  state_in = S_RD_PICK;
               end
            end
         end
         S_RD_PICK: state_in = S_WR_PICK;
         S_WR_PICK: begin
            res_topic_in = pick_ff;
            res_err_in   = 1'b0;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_topic_in = rsp_topic_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_topic_in = res_topic_ff;
         rsp_err_in   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rv_ff        <= 1'b0;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= ALPHA_RESET;
         beta_ff      <= BETA_RESET;
         topics_ff    <= TOPICS_RESET;
         vocab_ff     <= VOCAB_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rv_ff        <= rv_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         topics_ff    <= topics_in;
         vocab_ff     <= vocab_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      doc_ff       <= doc_in;
      term_ff      <= term_in;
      topic_ff     <= topic_in;
      rnd_ff       <= rnd_in;
      wk_ff        <= wk_in;
      wd_ff        <= wd_in;
      sk_ff        <= sk_in;
      rtag_ff      <= rtag_in;
      stag_ff      <= stag_in;
      pick_ff      <= pick_in;
      sum_ff       <= sum_in;
      plo_ff       <= plo_in;
      thr_ff       <= thr_in;
      run_ff       <= run_in;
      res_topic_ff <= res_topic_in;
      res_err_ff   <= res_err_in;
      rsp_topic_ff <= rsp_topic_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.new_topic = rsp_topic_ff;
   assign rsp_bus.error     = rsp_err_ff;

endmodule

// File: hw/rtl/lgts_div.sv
// Pipelined restoring divider: weight = min(floor(num*256/den), 2^32-1).
// One quotient bit per stage; depends on lgts_pkg.
module lgts_div (
   input  logic                  clock,
   input  logic                  reset,
   input  lgts_pkg::div_in_type  div_in,
   output lgts_pkg::div_out_type div_out
);
   import lgts_pkg::*;

   typedef struct packed {
      logic                   valid;
      logic                   sat;
      logic [TOPIC_BITS-1:0]  tag;
      logic [DEN_BITS-1:0]    rem;
      logic [WEIGHT_BITS-1:0] quo;
      logic [DEN_BITS-1:0]    den;
   } stage_type;

   stage_type                          stage_ff [0:WEIGHT_BITS];
   stage_type                          stage_in [0:WEIGHT_BITS];
   logic [DIVD_BITS-1:0]               dividend;
   logic [DIVD_BITS-WEIGHT_BITS-1:0]   head;

   assign dividend = {div_in.num, {FRAC_BITS{1'b0}}};
   assign head     = dividend[DIVD_BITS-1:WEIGHT_BITS];

   always_comb begin
      stage_in[0].valid = div_in.valid;
      stage_in[0].tag   = div_in.tag;
      stage_in[0].den   = div_in.den;
      stage_in[0].sat   = (head >= (DIVD_BITS-WEIGHT_BITS)'(div_in.den));
      stage_in[0].rem   = DEN_BITS'(head);
      stage_in[0].quo   = dividend[WEIGHT_BITS-1:0];
   end

   for (genvar i = 1; i <= WEIGHT_BITS; i++) begin : g_step
      logic [DEN_BITS:0] trial;
      logic [DEN_BITS:0] diff;
      assign trial = {stage_ff[i-1].rem, stage_ff[i-1].quo[WEIGHT_BITS-1]};
      assign diff  = trial - {1'b0, stage_ff[i-1].den};
      always_comb begin
         stage_in[i] = stage_ff[i-1];
         if (trial >= {1'b0, stage_ff[i-1].den}) begin
            stage_in[i].rem = diff[DEN_BITS-1:0];
            stage_in[i].quo = {stage_ff[i-1].quo[WEIGHT_BITS-2:0], 1'b1};
         end else begin
            stage_in[i].rem = trial[DEN_BITS-1:0];
            stage_in[i].quo = {stage_ff[i-1].quo[WEIGHT_BITS-2:0], 1'b0};
         end
      end
   end

   for (genvar s = 0; s <= WEIGHT_BITS; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s] <= '0;
         end else begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign div_out.valid  = stage_ff[WEIGHT_BITS].valid;
   assign div_out.tag    = stage_ff[WEIGHT_BITS].tag;
   assign div_out.weight = stage_ff[WEIGHT_BITS].sat ? {WEIGHT_BITS{1'b1}}
                                                     : stage_ff[WEIGHT_BITS].quo;

endmodule

// File: hw/rtl/lgts_checker.sv
// Port-level checker for the LDA token sampler, bound to the top level.
// Depends on lgts_pkg and lda_gibbs_token_sampler_assert.svh.
`include "lda_gibbs_token_sampler_assert.svh"

module lgts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lgts_pkg::TOPIC_BITS-1:0] rsp_new_topic,
   input logic                            rsp_error
);
   import lgts_pkg::*;

   // clearing pass holds off requests
   `LGTS_ASSERT_RESET(a_busy_after_reset, !req_ready)
   // one beat in flight at a time
   `LGTS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
   `LGTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_new_topic) && $stable(rsp_error))

endmodule

bind lda_gibbs_token_sampler lgts_checker u_lgts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_new_topic (rsp_bus.new_topic),
   .rsp_error     (rsp_bus.error)
);
